FILE: rtl/core/cpws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpws_pkg
// Shared types, constants and helpers of the clipped pixel writer / scaler.
// ----------------------------------------------------------------------------
package cpws_pkg;

  // Frame geometry
  localparam int FB_WIDTH  = 320;
  localparam int FB_HEIGHT = 240;
  localparam int FB_PIXELS = FB_WIDTH * FB_HEIGHT;
  localparam int COL_W     = (FB_WIDTH > 1) ? $clog2(FB_WIDTH) : 1;
  localparam int ROW_W     = (FB_HEIGHT > 1) ? $clog2(FB_HEIGHT) : 1;
  localparam int ADDR_W    = (FB_PIXELS > 1) ? $clog2(FB_PIXELS) : 1;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int POS_W   = 16;
  localparam int COLOR_W = 16;
  localparam int CH_W    = 8;
  localparam int CLIP_W  = 15;
  localparam int STEP_W  = 22;
  localparam int FRAC_W  = 16;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 22;

  // Scaling product: positive coordinate magnitude times step
  localparam int MAG_W  = POS_W - 1;
  localparam int PROD_W = MAG_W + STEP_W;
  localparam int SRC_W  = PROD_W - FRAC_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_CURSOR = 2'd0,
    KIND_PUT    = 2'd1,
    KIND_SCAN   = 2'd2
  } kind_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_FORMAT   = 3'd0,
    REG_CLIP_L   = 3'd1,
    REG_CLIP_T   = 3'd2,
    REG_CLIP_W   = 3'd3,
    REG_CLIP_H   = 3'd4,
    REG_KEY      = 3'd5,
    REG_STEP_X   = 3'd6,
    REG_STEP_Y   = 3'd7
  } cfg_reg_t;

  localparam logic FMT_RGB565   = 1'b0;
  localparam logic FMT_ARGB4444 = 1'b1;

  // Register reset values
  localparam logic [CLIP_W-1:0] CLIP_W_RST = CLIP_W'(320);
  localparam logic [CLIP_W-1:0] CLIP_H_RST = CLIP_W'(240);
  localparam logic [STEP_W-1:0] STEP_RST   = STEP_W'(65537);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // Expand a stored pixel to 8 bits per channel
  function automatic rgb_t expand(input logic fmt, input logic [COLOR_W-1:0] c);
    rgb_t o;
    if (fmt == FMT_RGB565) begin
      o.red   = {c[15:11], 3'b000};
      o.green = {c[10:5], 2'b00};
      o.blue  = {c[4:0], 3'b000};
    end else begin
      o.red   = {c[11:8], 4'b0000};
      o.green = {c[7:4], 4'b0000};
      o.blue  = {c[3:0], 4'b0000};
    end
    return o;
  endfunction

endpackage

FILE: rtl/core/cpws_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpws channel interfaces
// Command input, result output and register write channels.
// ----------------------------------------------------------------------------
interface cpws_in_if;
  logic                                valid;
  logic                                ready;
  logic [cpws_pkg::KIND_W-1:0]         kind;
  logic signed [cpws_pkg::POS_W-1:0]   pos_x;
  logic signed [cpws_pkg::POS_W-1:0]   pos_y;
  logic [cpws_pkg::COLOR_W-1:0]        color;

  modport source (output valid, kind, pos_x, pos_y, color, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, color, output ready);
endinterface

interface cpws_out_if;
  logic                        valid;
  logic                        ready;
  logic                        stored;
  logic [cpws_pkg::CH_W-1:0]   red;
  logic [cpws_pkg::CH_W-1:0]   green;
  logic [cpws_pkg::CH_W-1:0]   blue;

  modport source (output valid, stored, red, green, blue, input ready);
  modport sink   (input valid, stored, red, green, blue, output ready);
endinterface

interface cpws_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cpws_pkg::CIDX_W-1:0]    index;
  logic [cpws_pkg::CDATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/clipped_pixel_writer_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_pixel_writer_scaler
// Frame store with a clipped, color-keyed pixel writer and a nearest-neighbor
// scaled read path that expands pixels to 8-bit RGB.
// ----------------------------------------------------------------------------
// Usage:
//   pix  - command items: set cursor, put pixel at cursor (cursor advances and
//          wraps to the next row), or scan read of an output coordinate.
//   res  - one result item per command: stored flag for put pixel, expanded
//          RGB for scan read, all zero otherwise.
//   cfg  - register writes (format, clip window, color key, 6.16 steps);
//          always ready; registers are to be written only while the block is
//          idle, which the block itself does not enforce.
// Stages: the accept edge registers the scaling products and the clip
//   decision in stage 1; stage 2 does the frame store access as it advances,
//   and its read data register feeds the result.
// Throughput: one item per cycle unless the receiver stalls; all frame store
//   accesses use a single write and a single read port in program order, so
//   a scan read always sees every earlier put pixel without forwarding.
// Reset clears the cursor, the pipeline and the registers to their defaults;
//   the frame store itself is not cleared.
// A stalled receiver freezes both stages; the input still accepts one item
//   into the first stage while the result waits.
// ----------------------------------------------------------------------------
module clipped_pixel_writer_scaler (
  input  logic              clk,
  input  logic              rst,
  cpws_in_if.sink           pix,
  cpws_out_if.source        res,
  cpws_cfg_if.sink          cfg
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                                  pixel_format;
  logic signed [cpws_pkg::POS_W-1:0]     clip_left;
  logic signed [cpws_pkg::POS_W-1:0]     clip_top;
  logic [cpws_pkg::CLIP_W-1:0]           clip_width;
  logic [cpws_pkg::CLIP_W-1:0]           clip_height;
  logic [cpws_pkg::COLOR_W-1:0]          color_key;
  logic [cpws_pkg::STEP_W-1:0]           step_x;
  logic [cpws_pkg::STEP_W-1:0]           step_y;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= cpws_pkg::FMT_RGB565;
      clip_left    <= '0;
      clip_top     <= '0;
      clip_width   <= cpws_pkg::CLIP_W_RST;
      clip_height  <= cpws_pkg::CLIP_H_RST;
      color_key    <= '0;
      step_x       <= cpws_pkg::STEP_RST;
      step_y       <= cpws_pkg::STEP_RST;
    end else if (cfg.valid) begin
      unique case (cpws_pkg::cfg_reg_t'(cfg.index))
        cpws_pkg::REG_FORMAT: pixel_format <= cfg.data[0];
        cpws_pkg::REG_CLIP_L: clip_left    <= cfg.data[cpws_pkg::POS_W-1:0];
        cpws_pkg::REG_CLIP_T: clip_top     <= cfg.data[cpws_pkg::POS_W-1:0];
        cpws_pkg::REG_CLIP_W: clip_width   <= cfg.data[cpws_pkg::CLIP_W-1:0];
        cpws_pkg::REG_CLIP_H: clip_height  <= cfg.data[cpws_pkg::CLIP_W-1:0];
        cpws_pkg::REG_KEY:    color_key    <= cfg.data[cpws_pkg::COLOR_W-1:0];
        cpws_pkg::REG_STEP_X: step_x       <= cfg.data[cpws_pkg::STEP_W-1:0];
        cpws_pkg::REG_STEP_Y: step_y       <= cfg.data[cpws_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic s2_valid;
  logic advance;
  logic take;

  assign advance   = !s2_valid || res.ready;
  assign pix.ready = !s1_valid || advance;
  assign take      = pix.valid && pix.ready;

  // --------------------------------------------------------------------------
  // Cursor and put-pixel qualification (accept side)
  // --------------------------------------------------------------------------
  logic signed [cpws_pkg::POS_W-1:0] cursor_col;
  logic signed [cpws_pkg::POS_W-1:0] cursor_row;

  localparam logic signed [cpws_pkg::POS_W-1:0] FbWidthS =
    cpws_pkg::POS_W'(cpws_pkg::FB_WIDTH);
  localparam logic signed [cpws_pkg::POS_W-1:0] FbHeightS =
    cpws_pkg::POS_W'(cpws_pkg::FB_HEIGHT);

  logic signed [cpws_pkg::POS_W:0]   x_ext, y_ext, left_ext, top_ext;
  logic signed [cpws_pkg::POS_W:0]   right_ext, bottom_ext;
  logic                              clipped, in_frame, put_hit;
  logic [cpws_pkg::COLOR_W-1:0]      put_data;
  logic signed [cpws_pkg::POS_W-1:0] col_inc;
  logic signed [cpws_pkg::POS_W-1:0] row_inc;
  logic                              row_wrap;

  always_comb begin
    x_ext      = {cursor_col[cpws_pkg::POS_W-1], cursor_col};
    y_ext      = {cursor_row[cpws_pkg::POS_W-1], cursor_row};
    left_ext   = {clip_left[cpws_pkg::POS_W-1], clip_left};
    top_ext    = {clip_top[cpws_pkg::POS_W-1], clip_top};
    // window edges summed at full width, no wrap
    right_ext  = left_ext + $signed({2'b00, clip_width});
    bottom_ext = top_ext + $signed({2'b00, clip_height});
    clipped    = (x_ext < left_ext) || (y_ext < top_ext) ||
                 (x_ext >= right_ext) || (y_ext >= bottom_ext);
    in_frame   = !cursor_col[cpws_pkg::POS_W-1] && !cursor_row[cpws_pkg::POS_W-1] &&
                 (cursor_col < FbWidthS) && (cursor_row < FbHeightS);
    put_hit    = !clipped && in_frame && (pix.color != color_key);
    put_data   = (pixel_format == cpws_pkg::FMT_ARGB4444) ?
                 {pix.color[cpws_pkg::COLOR_W-5:0], 4'b0000} : pix.color;
    col_inc    = cursor_col + cpws_pkg::POS_W'(1);
    row_inc    = cursor_row + cpws_pkg::POS_W'(1);
    row_wrap   = (col_inc >= FbWidthS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (take) begin
      if (pix.kind == cpws_pkg::KIND_CURSOR) begin
        cursor_col <= pix.pos_x;
        cursor_row <= pix.pos_y;
      end else if (pix.kind == cpws_pkg::KIND_PUT) begin
        if (row_wrap) begin
          cursor_col <= '0;
          cursor_row <= row_inc;
        end else begin
          cursor_col <= col_inc;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: scaling products, write qualification, cursor location
  // --------------------------------------------------------------------------
  logic [cpws_pkg::KIND_W-1:0]   s1_kind;
  logic                          s1_we;
  logic [cpws_pkg::COLOR_W-1:0]  s1_wdata;
  logic [cpws_pkg::COL_W-1:0]    s1_col;
  logic [cpws_pkg::ROW_W-1:0]    s1_row;
  logic [cpws_pkg::PROD_W-1:0]   s1_prod_x, s1_prod_y;
  logic                          s1_neg_x, s1_neg_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix.ready) begin
      s1_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_kind   <= pix.kind;
      s1_we     <= (pix.kind == cpws_pkg::KIND_PUT) && put_hit;
      s1_wdata  <= put_data;
      s1_col    <= cursor_col[cpws_pkg::COL_W-1:0];
      s1_row    <= cursor_row[cpws_pkg::ROW_W-1:0];
      s1_prod_x <= cpws_pkg::PROD_W'(pix.pos_x[cpws_pkg::MAG_W-1:0]) *
                   cpws_pkg::PROD_W'(step_x);
      s1_prod_y <= cpws_pkg::PROD_W'(pix.pos_y[cpws_pkg::MAG_W-1:0]) *
                   cpws_pkg::PROD_W'(step_y);
      s1_neg_x  <= pix.pos_x[cpws_pkg::POS_W-1];
      s1_neg_y  <= pix.pos_y[cpws_pkg::POS_W-1];
    end
  end

  // Source coordinate: integer part of the product, saturated to the frame
  logic [cpws_pkg::SRC_W-1:0]  src_x, src_y;
  logic [cpws_pkg::COL_W-1:0]  sat_x;
  logic [cpws_pkg::ROW_W-1:0]  sat_y;
  logic [cpws_pkg::COL_W-1:0]  acc_col;
  logic [cpws_pkg::ROW_W-1:0]  acc_row;
  logic [cpws_pkg::ADDR_W-1:0] acc_addr;
  logic                        s1_scan;

  always_comb begin
    src_x = s1_prod_x[cpws_pkg::PROD_W-1:cpws_pkg::FRAC_W];
    src_y = s1_prod_y[cpws_pkg::PROD_W-1:cpws_pkg::FRAC_W];
    if (s1_neg_x) begin
      sat_x = '0;
    end else if (src_x >= cpws_pkg::SRC_W'(cpws_pkg::FB_WIDTH)) begin
      sat_x = cpws_pkg::COL_W'(cpws_pkg::FB_WIDTH - 1);
    end else begin
      sat_x = src_x[cpws_pkg::COL_W-1:0];
    end
    if (s1_neg_y) begin
      sat_y = '0;
    end else if (src_y >= cpws_pkg::SRC_W'(cpws_pkg::FB_HEIGHT)) begin
      sat_y = cpws_pkg::ROW_W'(cpws_pkg::FB_HEIGHT - 1);
    end else begin
      sat_y = src_y[cpws_pkg::ROW_W-1:0];
    end
    s1_scan  = (s1_kind == cpws_pkg::KIND_SCAN);
    acc_col  = s1_scan ? sat_x : s1_col;
    acc_row  = s1_scan ? sat_y : s1_row;
    acc_addr = cpws_pkg::ADDR_W'(acc_row) * cpws_pkg::ADDR_W'(cpws_pkg::FB_WIDTH) +
               cpws_pkg::ADDR_W'(acc_col);
  end

  // --------------------------------------------------------------------------
  // Stage 2: frame store access (one write port, one registered read port)
  // --------------------------------------------------------------------------
  logic [cpws_pkg::COLOR_W-1:0] frame_mem [cpws_pkg::FB_PIXELS];
  logic [cpws_pkg::COLOR_W-1:0] rd_data;
  logic [cpws_pkg::KIND_W-1:0]  s2_kind;
  logic                         s2_stored;

  always_ff @(posedge clk) begin
    if (advance && s1_valid && s1_we) begin
      frame_mem[acc_addr] <= s1_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && s1_scan) begin
      rd_data <= frame_mem[acc_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      s2_kind   <= s1_kind;
      s2_stored <= s1_we;
    end
  end

  // --------------------------------------------------------------------------
  // Result
  // --------------------------------------------------------------------------
  cpws_pkg::rgb_t pix_rgb;

  assign pix_rgb    = cpws_pkg::expand(pixel_format, rd_data);
  assign res.valid  = s2_valid;
  assign res.stored = s2_stored;
  assign res.red    = (s2_kind == cpws_pkg::KIND_SCAN) ? pix_rgb.red   : '0;
  assign res.green  = (s2_kind == cpws_pkg::KIND_SCAN) ? pix_rgb.green : '0;
  assign res.blue   = (s2_kind == cpws_pkg::KIND_SCAN) ? pix_rgb.blue  : '0;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - clipped pixel writer / scaler testbench
// Drives cursor, put-pixel and scan-read items with random sender bursts and
// receiver stalls. A scoreboard class keeps its own copy of the cursor,
// registers and frame, predicts one result per item and checks each one.
// ----------------------------------------------------------------------------
module tb;
  import cpws_pkg::*;

  // kind code with no defined operation; the block must answer all-zero
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Longest stretch without any handshake in a correct run is a receiver
  // stall plus a sender gap plus the two-stage pipe; the limit is that
  // stretch taken many times over.
  localparam int IDLE_LIMIT = 4000;

  localparam int RANDOM_ITEMS = 500;

  // --------------------------------------------------------------------------
  // Scoreboard: cursor, registers and frame copy, plus the queue of results
  // still owed by the block.
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    typedef struct packed {
      logic         stored;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
    } pix_result_t;

    logic [COLOR_W-1:0]        frame [FB_PIXELS];
    bit                        written [FB_PIXELS];
    int                        written_q [$];
    logic signed [POS_W-1:0]   cur_col;
    logic signed [POS_W-1:0]   cur_row;
    logic                      fmt;
    logic signed [POS_W-1:0]   clip_l;
    logic signed [POS_W-1:0]   clip_t;
    logic [CLIP_W-1:0]         clip_w;
    logic [CLIP_W-1:0]         clip_h;
    logic [COLOR_W-1:0]        key;
    logic [STEP_W-1:0]         step_x;
    logic [STEP_W-1:0]         step_y;
    pix_result_t               owed_q [$];
    int errors;
    int n_items;
    int n_stored;
    int n_scans;

    function new();
      cur_col = '0;
      cur_row = '0;
      fmt     = FMT_RGB565;
      clip_l  = '0;
      clip_t  = '0;
      clip_w  = CLIP_W_RST;
      clip_h  = CLIP_H_RST;
      key     = '0;
      step_x  = STEP_RST;
      step_y  = STEP_RST;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CDATA_W-1:0] d);
      case (idx)
        REG_FORMAT: fmt    = d[0];
        REG_CLIP_L: clip_l = d[POS_W-1:0];
        REG_CLIP_T: clip_t = d[POS_W-1:0];
        REG_CLIP_W: clip_w = d[CLIP_W-1:0];
        REG_CLIP_H: clip_h = d[CLIP_W-1:0];
        REG_KEY:    key    = d[COLOR_W-1:0];
        REG_STEP_X: step_x = d[STEP_W-1:0];
        REG_STEP_Y: step_y = d[STEP_W-1:0];
      endcase
    endfunction

    // 6.16 nearest-neighbor source coordinate, clamped into [0, lim-1]
    function int map_src(logic signed [POS_W-1:0] pos, logic [STEP_W-1:0] step, int lim);
      longint p;
      if (pos <= 0) return 0;
      p = (longint'(pos) * longint'(step)) >> FRAC_W;
      return (p >= lim) ? lim - 1 : int'(p);
    endfunction

    function void note_input(logic [KIND_W-1:0] kind, logic signed [POS_W-1:0] x,
                             logic signed [POS_W-1:0] y, logic [COLOR_W-1:0] color);
      pix_result_t r;
      int cx, cy, addr, sx, sy;
      bit clipped, in_frame;
      logic [COLOR_W-1:0] c;
      logic signed [POS_W-1:0] nx;
      r = '0;
      case (kind)
        KIND_CURSOR: begin
          cur_col = x;
          cur_row = y;
        end
        KIND_PUT: begin
          cx = cur_col;
          cy = cur_row;
          // window edges summed in 32 bits, so no wrap at the 16-bit boundary
          clipped = cx < int'(clip_l) || cy < int'(clip_t) ||
                    cx >= int'(clip_l) + int'(clip_w) || cy >= int'(clip_t) + int'(clip_h);
          in_frame = cx >= 0 && cy >= 0 && cx < FB_WIDTH && cy < FB_HEIGHT;
          if (!clipped && in_frame && color != key) begin
            c = (fmt == FMT_ARGB4444) ? {color[11:0], 4'h0} : color;
            addr = cy * FB_WIDTH + cx;
            frame[addr] = c;
            if (!written[addr]) begin
              written[addr] = 1'b1;
              written_q.push_back(addr);
            end
            r.stored = 1'b1;
            n_stored++;
          end
          // column wraps in 16 bits; only a column at or past the frame edge
          // moves to the next row
          nx = cur_col + 16'sd1;
          if (int'(nx) >= FB_WIDTH) begin
            nx = '0;
            cur_row = cur_row + 16'sd1;
          end
          cur_col = nx;
        end
        KIND_SCAN: begin
          sx = map_src(x, step_x, FB_WIDTH);
          sy = map_src(y, step_y, FB_HEIGHT);
          c = frame[sy * FB_WIDTH + sx];
          if (fmt == FMT_RGB565) begin
            r.red   = 8'((c & 16'hF800) >> 8);
            r.green = 8'((c & 16'h07E0) >> 3);
            r.blue  = 8'((c & 16'h001F) << 3);
          end else begin
            r.red   = 8'((c & 16'h0F00) >> 4);
            r.green = 8'(c & 16'h00F0);
            r.blue  = 8'((c & 16'h000F) << 4);
          end
          n_scans++;
        end
        default: ;
      endcase
      owed_q.push_back(r);
      n_items++;
    endfunction

    function void check_result(pix_result_t got);
      pix_result_t e;
      if (owed_q.size() == 0) begin
        $error("result with nothing owed: stored=%0d rgb=%02h%02h%02h",
               got.stored, got.red, got.green, got.blue);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (got.stored !== e.stored) begin
        $error("stored: expected %0d, got %0d", e.stored, got.stored);
        errors++;
      end
      if (got.red !== e.red) begin
        $error("red: expected %02h, got %02h", e.red, got.red);
        errors++;
      end
      if (got.green !== e.green) begin
        $error("green: expected %02h, got %02h", e.green, got.green);
        errors++;
      end
      if (got.blue !== e.blue) begin
        $error("blue: expected %02h, got %02h", e.blue, got.blue);
        errors++;
      end
    endfunction

    function void check_leftover();
      if (owed_q.size() != 0) begin
        $error("%0d results never arrived", owed_q.size());
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;

  cpws_in_if  pix_if ();
  cpws_out_if res_if ();
  cpws_cfg_if cfg_if ();

  clipped_pixel_writer_scaler u_dut (
    .clk (clk),
    .rst (rst),
    .pix (pix_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  frame_scoreboard sb = new();

  int burst_left;
  int cfg_writes;
  int items_sent;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side: sampled on the rising edge, ready driven on the falling edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      sb.check_result({res_if.stored, res_if.red, res_if.green, res_if.blue});
  end

  typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_STALLS} rx_mode_t;
  rx_mode_t rx_mode;
  int rx_left;
  int rx_period;
  int rx_tick;
  int rx_stall;

  // Receiver switches its stall pattern at random: always ready, coin toss,
  // periodic ready, or mostly ready with long stalls.
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      rx_left  = 0;
      rx_stall = 0;
      rx_tick  = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        rx_left   = $urandom_range(32, 200);
        rx_period = $urandom_range(2, 6);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:     res_if.ready <= 1'b1;
        RX_COIN:     res_if.ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: res_if.ready <= (rx_tick % rx_period == 0);
        default: begin
          if (rx_stall > 0) begin
            rx_stall--;
            res_if.ready <= 1'b0;
          end else begin
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(4, 20);
          end
        end
      endcase
    end
  end

  // Watchdog: any handshake on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results owed",
               IDLE_LIMIT, sb.owed_q.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers (called at a falling edge, return at a falling edge)
  // --------------------------------------------------------------------------

  // One command item. The sender runs in bursts; valid is only dropped when
  // a gap follows, so it never falls and rises within one time step.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic signed [POS_W-1:0] x,
                           input logic signed [POS_W-1:0] y, input logic [COLOR_W-1:0] color);
    int gap;
    pix_if.valid <= 1'b1;
    pix_if.kind  <= kind;
    pix_if.pos_x <= x;
    pix_if.pos_y <= y;
    pix_if.color <= color;
    do @(posedge clk); while (!pix_if.ready);
    sb.note_input(kind, x, y, color);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // a long burst now and then gives stretches with no sender idling
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Leaves valid high; the caller drops it after the last write of a group.
  task automatic write_reg(input cfg_reg_t idx, input logic [CDATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, d);
    cfg_writes++;
    @(negedge clk);
  endtask

  // Wait for the block to go idle before touching registers. Every item
  // owes a result, so an empty queue means the pipe is empty.
  task automatic drain();
    pix_if.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [POS_W-1:0] neg_pos();
    return 16'(-int'($urandom_range(1, 32768)));
  endfunction

  function automatic logic signed [POS_W-1:0] big_pos();
    return 16'($urandom_range(16384, 32767));
  endfunction

  // Output coordinate that lands on source t for this step, if one exists
  function automatic logic signed [POS_W-1:0] aim_pos(int t, logic [STEP_W-1:0] step);
    longint q;
    if (t == 0) return $urandom_range(0, 1) ? 16'sd0 : neg_pos();
    if (step == 0) return 16'($urandom_range(1, 32767));
    q = ((longint'(t) << FRAC_W) + longint'(step) - 1) / longint'(step);
    if (q > 32767) q = 32767;
    return 16'(q);
  endfunction

  // Coordinate inside both the clip window and the frame when they overlap
  function automatic logic signed [POS_W-1:0] pick_in(int left, int span, int lim);
    int lo, hi;
    lo = (left > 0) ? left : 0;
    hi = (left + span - 1 < lim - 1) ? left + span - 1 : lim - 1;
    if (lo > hi) return 16'($urandom_range(0, lim - 1));
    return 16'($urandom_range(lo, hi));
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    return ($urandom_range(0, 7) == 0) ? sb.key : 16'($urandom());
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 22'h3FFFFF;
      2: return 22'h010000;
      3: return 22'h008000;
      4: return 22'h020000;
      5: return 22'($urandom_range(1, 22'h3FFFFF));
      6: return 22'($urandom_range(22'h004000, 22'h018000));
      default: return 22'h010001;
    endcase
  endfunction

  // Scan read of a pixel that has been written. Candidates aim at a written
  // pixel or hit the negative / saturating ends; origin is the fallback.
  task automatic send_scan();
    logic signed [POS_W-1:0] px, py;
    int a, sx, sy;
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < 40 && !hit; i++) begin
      a = sb.written_q[$urandom_range(0, sb.written_q.size() - 1)];
      case ($urandom_range(0, 7))
        0: px = neg_pos();
        1: px = big_pos();
        default: px = aim_pos(a % FB_WIDTH, sb.step_x);
      endcase
      case ($urandom_range(0, 7))
        0: py = neg_pos();
        1: py = big_pos();
        default: py = aim_pos(a / FB_WIDTH, sb.step_y);
      endcase
      sx = sb.map_src(px, sb.step_x, FB_WIDTH);
      sy = sb.map_src(py, sb.step_y, FB_HEIGHT);
      hit = sb.written[sy * FB_WIDTH + sx];
    end
    if (!hit) begin
      px = '0;
      py = '0;
    end
    send_item(KIND_SCAN, px, py, 16'($urandom()));
  endtask

  // New register setting between phases; every register is rewritten
  task automatic random_setting();
    logic signed [POS_W-1:0] l, t;
    logic [CLIP_W-1:0] w, h;
    logic [COLOR_W-1:0] k;
    case ($urandom_range(0, 5))
      0: begin
        l = '0; t = '0; w = CLIP_W_RST; h = CLIP_H_RST;
      end
      1, 2: begin
        l = 16'($urandom_range(0, 300));
        t = 16'($urandom_range(0, 220));
        w = 15'($urandom_range(1, 200));
        h = 15'($urandom_range(1, 200));
      end
      3: begin
        // far-negative edges with the widest window
        l = neg_pos(); t = neg_pos(); w = 15'h7FFF; h = 15'h7FFF;
      end
      4: begin
        // empty window: nothing can be stored
        l = '0; t = '0;
        w = $urandom_range(0, 1) ? 15'd0 : CLIP_W_RST;
        h = (w == 0) ? CLIP_H_RST : 15'd0;
      end
      default: begin
        l = 16'($urandom()); t = 16'($urandom());
        w = 15'($urandom()); h = 15'($urandom());
      end
    endcase
    case ($urandom_range(0, 3))
      0: k = '0;
      1: k = 16'hFFFF;
      default: k = 16'($urandom());
    endcase
    write_reg(REG_FORMAT, CDATA_W'($urandom_range(0, 1)));
    write_reg(REG_CLIP_L, CDATA_W'(l));
    write_reg(REG_CLIP_T, CDATA_W'(t));
    write_reg(REG_CLIP_W, CDATA_W'(w));
    write_reg(REG_CLIP_H, CDATA_W'(h));
    write_reg(REG_KEY, CDATA_W'(k));
    write_reg(REG_STEP_X, pick_step());
    write_reg(REG_STEP_Y, pick_step());
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Set cursor (mostly inside the window), a run of puts, a few scans
  task automatic draw_run();
    logic signed [POS_W-1:0] cx, cy;
    int n;
    cy = pick_in(sb.clip_t, sb.clip_h, FB_HEIGHT);
    case ($urandom_range(0, 7))
      0: begin
        cx = 16'($urandom());
        cy = 16'($urandom());
      end
      1: cx = 16'($urandom_range(FB_WIDTH - 20, FB_WIDTH - 1));  // wraps soon
      default: cx = pick_in(sb.clip_l, sb.clip_w, FB_WIDTH);
    endcase
    send_item(KIND_CURSOR, cx, cy, 16'($urandom()));
    n = $urandom_range(1, 12);
    repeat (n) send_item(KIND_PUT, 16'($urandom()), 16'($urandom()), pick_color());
    n = $urandom_range(1, 4);
    repeat (n) send_scan();
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 3))
      0: send_item(KIND_CURSOR, 16'($urandom()), 16'($urandom()), 16'($urandom()));
      1: send_item(KIND_PUT, 16'($urandom()), 16'($urandom()), 16'($urandom()));
      2: send_scan();
      default: send_item(KIND_UNUSED, 16'($urandom()), 16'($urandom()), 16'($urandom()));
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int next_cfg;
    int since_cfg;
    int start;
    int n;
    rst          = 1'b1;
    pix_if.valid = 1'b0;
    pix_if.kind  = KIND_CURSOR;
    pix_if.pos_x = '0;
    pix_if.pos_y = '0;
    pix_if.color = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_FORMAT;
    cfg_if.data  = '0;
    idle_cycles  = 0;
    burst_left   = 0;
    cfg_writes   = 0;
    items_sent   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed, reset settings (RGB565, full-frame window, key 0) ----
    // origin stored; next pixel equals the key and is dropped
    send_item(KIND_CURSOR, 16'sd0, 16'sd0, 16'h0000);
    send_item(KIND_PUT, 16'sd0, 16'sd0, 16'hFFFF);
    send_item(KIND_PUT, 16'sd0, 16'sd0, 16'h0000);
    // last pixel of the frame, then the cursor wraps to a row below the frame
    send_item(KIND_CURSOR, 16'sd319, 16'sd239, 16'h0000);
    send_item(KIND_PUT, 16'sd0, 16'sd0, 16'h8421);
    send_item(KIND_PUT, 16'sd0, 16'sd0, 16'h1234);
    // negative cursor is off-frame
    send_item(KIND_CURSOR, -16'sd1, 16'sd5, 16'h0000);
    send_item(KIND_PUT, 16'sd0, 16'sd0, 16'hABCD);
    // row counter wraps through the 16-bit boundary
    send_item(KIND_CURSOR, 16'sd319, 16'sd32767, 16'h0000);
    send_item(KIND_PUT, 16'sd0, 16'sd0, 16'h5555);
    send_item(KIND_PUT, 16'sd0, 16'sd0, 16'h5555);
    // end of row 0 wraps to the start of row 1
    send_item(KIND_CURSOR, 16'sd319, 16'sd0, 16'h0000);
    send_item(KIND_PUT, 16'sd0, 16'sd0, 16'h07E0);
    send_item(KIND_PUT, 16'sd0, 16'sd0, 16'h001F);
    // scans: origin, negative clamp, large clamp to the far corner, row 1
    send_item(KIND_SCAN, 16'sd0, 16'sd0, 16'h0000);
    send_item(KIND_SCAN, -16'sd32768, -16'sd5, 16'hFFFF);
    send_item(KIND_SCAN, 16'sd32767, 16'sd32767, 16'h0000);
    send_item(KIND_SCAN, 16'sd0, 16'sd1, 16'h0000);
    // undefined kind answers with an all-zero result
    send_item(KIND_UNUSED, -16'sd32768, 16'sd32767, 16'hFFFF);
    drain();

    // ---- ARGB4444, extreme window whose right edge sums to -1, steps max/0 ----
    write_reg(REG_FORMAT, CDATA_W'(FMT_ARGB4444));
    write_reg(REG_CLIP_L, CDATA_W'(16'h8000));
    write_reg(REG_CLIP_T, CDATA_W'(16'h8000));
    write_reg(REG_CLIP_W, CDATA_W'(15'h7FFF));
    write_reg(REG_CLIP_H, CDATA_W'(15'h7FFF));
    write_reg(REG_KEY, CDATA_W'(16'hFFFF));
    write_reg(REG_STEP_X, 22'h3FFFFF);
    write_reg(REG_STEP_Y, 22'h000000);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
    send_item(KIND_CURSOR, 16'sd5, 16'sd5, 16'h0000);
    send_item(KIND_PUT, 16'sd0, 16'sd0, 16'h1234);
    send_item(KIND_SCAN, 16'sd10, 16'sd100, 16'h0000);
    drain();

    // ---- window from one pixel left of and above the frame, 1:1 steps ----
    write_reg(REG_CLIP_L, CDATA_W'(16'hFFFF));
    write_reg(REG_CLIP_T, CDATA_W'(16'hFFFF));
    write_reg(REG_CLIP_W, CDATA_W'(CLIP_W_RST));
    write_reg(REG_STEP_X, 22'h010000);
    write_reg(REG_STEP_Y, 22'h010000);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
    send_item(KIND_CURSOR, 16'sd2, 16'sd2, 16'h0000);
    send_item(KIND_PUT, 16'sd0, 16'sd0, 16'hFFFF);
    send_item(KIND_PUT, 16'sd0, 16'sd0, 16'h0FFF);
    send_item(KIND_SCAN, 16'sd3, 16'sd2, 16'h0000);

    // ---- random part: drawing runs, scan bursts, long put streams, noise ----
    start     = items_sent;
    since_cfg = 0;
    next_cfg  = $urandom_range(70, 130);
    while (items_sent - start < RANDOM_ITEMS) begin
      if (since_cfg >= next_cfg) begin
        drain();
        random_setting();
        since_cfg = 0;
        next_cfg  = $urandom_range(70, 130);
      end
      n = items_sent;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: draw_run();
        6, 7: repeat ($urandom_range(2, 6)) send_scan();
        8: repeat ($urandom_range(1, 4)) noise_item();
        default: begin
          // long put stream from near the row end, crossing row boundaries
          send_item(KIND_CURSOR, 16'($urandom_range(FB_WIDTH - 8, FB_WIDTH - 1)),
                    pick_in(sb.clip_t, sb.clip_h, FB_HEIGHT), 16'($urandom()));
          repeat ($urandom_range(8, 40))
            send_item(KIND_PUT, 16'($urandom()), 16'($urandom()), pick_color());
        end
      endcase
      since_cfg += items_sent - n;
    end

    drain();
    sb.check_leftover();
    $display("run covered %0d items: %0d pixels stored, %0d scan reads checked",
             sb.n_items, sb.n_stored, sb.n_scans);
    $display("%0d register writes across directed and random settings", cfg_writes);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d check failures", sb.errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
